// ===== sv/gpq_pkg.sv =====
// Shared constants, codes and float helper functions for the GELU approximation block.
package gpq_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned FP_W        = 32;
  localparam int unsigned ENTRY_W     = 10;
  localparam int unsigned COEF_W      = 3 * FP_W;
  localparam int unsigned SEG_INT_W   = 17;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic KIND_EVAL = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SEG_ORIGIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_SCALE  = 1'b1;

  localparam logic [FP_W-1:0] ORIGIN_RESET = 32'hC0A0_0000;
  localparam logic [FP_W-1:0] SCALE_RESET  = 32'h3F80_0000;
  localparam logic [FP_W-1:0] CANON_NAN    = 32'h7FC0_0000;
  localparam logic [30:0]     FIVE_MAG     = 31'h40A0_0000;
  localparam logic [30:0]     INF_MAG      = 31'h7F80_0000;

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    n = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) n = 5'(26 - i);
    end
    return n;
  endfunction

  // exponent field plus rounding increment; carry out of the fraction bumps the exponent
  function automatic logic [31:0] round_pack(input logic s, input logic [8:0] ef,
                                             input logic [22:0] m, input logic inc);
    logic [31:0] sum;
    logic [31:0] r;
    sum = {ef, m} + {31'd0, inc};
    if (sum[31:23] >= 9'd255) r = {s, 8'hFF, 23'd0};
    else r = {s, sum[30:0]};
    return r;
  endfunction

endpackage

// ===== sv/gpq_if.sv =====
// Request and result channel interfaces.
interface gpq_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [gpq_pkg::FP_W-1:0]     x_bits;
  logic [gpq_pkg::ENTRY_W-1:0]  entry_index;
  logic [gpq_pkg::FP_W-1:0]     coef_square;
  logic [gpq_pkg::FP_W-1:0]     coef_linear;
  logic [gpq_pkg::FP_W-1:0]     coef_constant;

  modport source (output valid, kind, x_bits, entry_index, coef_square, coef_linear,
                  coef_constant, input ready);
  modport sink (input valid, kind, x_bits, entry_index, coef_square, coef_linear,
                coef_constant, output ready);
endinterface

interface gpq_out_if;
  logic                     valid;
  logic                     ready;
  logic [gpq_pkg::FP_W-1:0] y_bits;

  modport source (output valid, y_bits, input ready);
  modport sink (input valid, y_bits, output ready);
endinterface

// ===== sv/gpq_fp_add.sv =====
// Two-stage binary32 adder, round to nearest even, canonical NaN.
module gpq_fp_add (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [gpq_pkg::FP_W-1:0] a_i,
  input  logic [gpq_pkg::FP_W-1:0] b_i,
  output logic [gpq_pkg::FP_W-1:0] y_o
);

  logic        swap;
  logic [31:0] big, sml;
  logic [23:0] sig_big, sig_sml;
  logic [7:0]  e_big, e_sml, d;
  logic [4:0]  dsh;
  logic [26:0] b_full, b_aln;
  logic        lost;
  logic [26:0] op_a, op_b;
  logic        eff_sub;
  logic        a_nan, b_nan, a_inf, b_inf;
  logic [27:0] sum_d;

  logic [27:0] sum_q;
  logic [7:0]  exp_q;
  logic        sign_q, zsign_q, nan_q, inf_q;
  logic [31:0] y_q;

  always_comb begin
    a_nan   = (a_i[30:23] == 8'hFF) && (a_i[22:0] != 23'd0);
    b_nan   = (b_i[30:23] == 8'hFF) && (b_i[22:0] != 23'd0);
    a_inf   = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'd0);
    b_inf   = (b_i[30:23] == 8'hFF) && (b_i[22:0] == 23'd0);
    swap    = b_i[30:0] > a_i[30:0];
    big     = swap ? b_i : a_i;
    sml     = swap ? a_i : b_i;
    sig_big = {|big[30:23], big[22:0]};
    sig_sml = {|sml[30:23], sml[22:0]};
    e_big   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    e_sml   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d       = e_big - e_sml;
    dsh     = (d >= 8'd27) ? 5'd27 : d[4:0];
    b_full  = {sig_sml, 3'b000};
    b_aln   = b_full >> dsh;
    lost    = |(b_full & ((27'd1 << dsh) - 27'd1));
    op_a    = {sig_big, 3'b000};
    op_b    = {b_aln[26:1], b_aln[0] | lost};
    eff_sub = big[31] ^ sml[31];
    sum_d   = eff_sub ? ({1'b0, op_a} - {1'b0, op_b}) : ({1'b0, op_a} + {1'b0, op_b});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q   <= sum_d;
      exp_q   <= e_big;
      sign_q  <= big[31];
      zsign_q <= eff_sub ? 1'b0 : big[31];
      nan_q   <= a_nan | b_nan | (a_inf & b_inf & eff_sub);
      inf_q   <= a_inf | b_inf;
    end
  end

  logic [4:0]  lz;
  logic [7:0]  lim;
  logic [4:0]  lsh;
  logic [26:0] norm;
  logic [8:0]  e_n;
  logic [8:0]  ef;
  logic        inc;
  logic [31:0] y_d;

  always_comb begin
    lz  = gpq_pkg::lzc27(sum_q[26:0]);
    lim = exp_q - 8'd1;
    lsh = ({3'd0, lz} > lim) ? lim[4:0] : lz;
    if (sum_q[27]) begin
      norm = {sum_q[27:2], sum_q[1] | sum_q[0]};
      e_n  = {1'b0, exp_q} + 9'd1;
    end else begin
      norm = sum_q[26:0] << lsh;
      e_n  = {1'b0, exp_q} - {4'd0, lsh};
    end
    ef  = norm[26] ? e_n : 9'd0;
    inc = norm[2] & (norm[1] | norm[0] | norm[3]);
    if (nan_q) y_d = gpq_pkg::CANON_NAN;
    else if (inf_q) y_d = {sign_q, 8'hFF, 23'd0};
    else if (sum_q == 28'd0) y_d = {zsign_q, 31'd0};
    else y_d = gpq_pkg::round_pack(sign_q, ef, norm[25:3], inc);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) y_q <= y_d;
  end

  assign y_o = y_q;

endmodule

// ===== sv/gpq_fp_mul.sv =====
// Two-stage binary32 multiplier, round to nearest even, canonical NaN.
module gpq_fp_mul (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [gpq_pkg::FP_W-1:0] a_i,
  input  logic [gpq_pkg::FP_W-1:0] b_i,
  output logic [gpq_pkg::FP_W-1:0] y_o
);

  logic               a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
  logic [23:0]        sig_a, sig_b, sig_an, sig_bn;
  logic [4:0]         lz_a, lz_b;
  logic signed [10:0] exp_a, exp_b, exp_d;
  logic [47:0]        prod_d;

  logic [47:0]        prod_q;
  logic signed [10:0] exp_q;
  logic               sign_q, nan_q, inf_q, zero_q;
  logic [31:0]        y_q;

  always_comb begin
    a_zero = a_i[30:0] == 31'd0;
    b_zero = b_i[30:0] == 31'd0;
    a_inf  = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'd0);
    b_inf  = (b_i[30:23] == 8'hFF) && (b_i[22:0] == 23'd0);
    a_nan  = (a_i[30:23] == 8'hFF) && (a_i[22:0] != 23'd0);
    b_nan  = (b_i[30:23] == 8'hFF) && (b_i[22:0] != 23'd0);
    sig_a  = {|a_i[30:23], a_i[22:0]};
    sig_b  = {|b_i[30:23], b_i[22:0]};
    lz_a   = gpq_pkg::lzc24(sig_a);
    lz_b   = gpq_pkg::lzc24(sig_b);
    sig_an = sig_a << lz_a;
    sig_bn = sig_b << lz_b;
    exp_a  = ((a_i[30:23] == 8'd0) ? 11'sd1 : $signed({3'd0, a_i[30:23]}))
             - $signed({6'd0, lz_a});
    exp_b  = ((b_i[30:23] == 8'd0) ? 11'sd1 : $signed({3'd0, b_i[30:23]}))
             - $signed({6'd0, lz_b});
    exp_d  = exp_a + exp_b - 11'sd127;
    prod_d = {24'd0, sig_an} * {24'd0, sig_bn};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      exp_q  <= exp_d;
      sign_q <= a_i[31] ^ b_i[31];
      nan_q  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
      inf_q  <= a_inf | b_inf;
      zero_q <= a_zero | b_zero;
    end
  end

  logic [47:0]        norm, shifted;
  logic signed [10:0] e_n, diff;
  logic [5:0]         sh;
  logic               lost, inc;
  logic [8:0]         ef;
  logic [31:0]        y_d;

  always_comb begin
    norm    = prod_q[47] ? prod_q : (prod_q << 1);
    e_n     = prod_q[47] ? (exp_q + 11'sd1) : exp_q;
    diff    = 11'sd1 - e_n;
    if (e_n >= 11'sd1) sh = 6'd0;
    else sh = (diff > 11'sd63) ? 6'd63 : diff[5:0];
    shifted = norm >> sh;
    lost    = |(norm & ((48'd1 << sh) - 48'd1));
    ef      = (e_n < 11'sd1) ? 9'd0 : e_n[8:0];
    inc     = shifted[23] & ((|shifted[22:0]) | lost | shifted[24]);
    if (nan_q) y_d = gpq_pkg::CANON_NAN;
    else if (inf_q) y_d = {sign_q, 8'hFF, 23'd0};
    else if (zero_q) y_d = {sign_q, 31'd0};
    else if (e_n >= 11'sd255) y_d = {sign_q, 8'hFF, 23'd0};
    else y_d = gpq_pkg::round_pack(sign_q, ef, shifted[46:24], inc);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) y_q <= y_d;
  end

  assign y_o = y_q;

endmodule

// ===== sv/gpq_coef_mem.sv =====
// Coefficient table RAM, one write and one registered read per cycle while en_i is high.
module gpq_coef_mem #(
  parameter int unsigned DEPTH = gpq_pkg::TABLE_DEPTH,
  parameter int unsigned AW    = 10
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [gpq_pkg::COEF_W-1:0] wdata_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [gpq_pkg::COEF_W-1:0] rdata_o
);

  logic [gpq_pkg::COEF_W-1:0] mem [DEPTH];
  logic [gpq_pkg::COEF_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) mem[waddr_i] <= wdata_i;
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/gelu_piecewise_quadratic.sv =====
// Top level: pipelined piecewise quadratic GELU over binary32 requests.
//
//   channel  | dir | handshake     | payload
//   in_if    | in  | valid/ready   | kind, x_bits, entry_index, coef_square/linear/constant
//   out_if   | out | valid/ready   | y_bits
//   cfg      | in  | cfg_we_i      | cfg_idx_i, cfg_data_i
//
// One request per cycle while the pipeline advances; each result passes the origin add,
// scale multiply, RAM read and fp units (two stages each, four in series after the RAM).
// Load requests write the RAM at the same stage where evaluations read it.
// The whole pipeline holds while a result waits and out_if.ready is low.
// Reset clears the valid bits and sets the two config registers to their reset values; the RAM is not cleared.
module gelu_piecewise_quadratic #(
  parameter int unsigned TABLE_DEPTH = gpq_pkg::TABLE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gpq_in_if.sink                        in_if,
  gpq_out_if.source                     out_if,
  input  logic                          cfg_we_i,
  input  logic [gpq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gpq_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IW       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned LAST     = 15;
  localparam int unsigned MUL1_OUT = 4;
  localparam int unsigned IDX      = 5;
  localparam int unsigned COEF     = 6;
  localparam int unsigned ADD2_IN  = 8;
  localparam int unsigned MUL3_IN  = 10;
  localparam int unsigned ADD3_IN  = 12;
  localparam int unsigned ADD3_OUT = 14;

  typedef struct packed {
    logic                     kind;
    logic [gpq_pkg::FP_W-1:0] x;
    logic                     lo;
    logic                     hi;
  } side_t;

  typedef struct packed {
    logic [gpq_pkg::ENTRY_W-1:0] entry;
    logic [gpq_pkg::COEF_W-1:0]  coef;
  } load_t;

  logic                     adv;
  logic [LAST:0]            v_q;
  side_t                    side_q [LAST+1];
  load_t                    load_q [IDX];
  logic [gpq_pkg::FP_W-1:0] origin_q, scale_q;
  logic [30:0]              in_mag;
  logic                     in_big;

  assign adv          = !out_if.valid || out_if.ready;
  assign in_if.ready  = adv;
  assign in_mag       = in_if.x_bits[30:0];
  assign in_big       = (in_mag > gpq_pkg::FIVE_MAG) && (in_mag <= gpq_pkg::INF_MAG);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= gpq_pkg::ORIGIN_RESET;
      scale_q  <= gpq_pkg::SCALE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gpq_pkg::REG_SEG_ORIGIN: origin_q <= cfg_data_i;
        gpq_pkg::REG_SEG_SCALE:  scale_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[LAST-1:0], in_if.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0].kind <= in_if.kind;
      side_q[0].x    <= in_if.x_bits;
      side_q[0].lo   <= in_if.x_bits[31] & in_big;
      side_q[0].hi   <= !in_if.x_bits[31] & in_big;
      load_q[0].entry <= in_if.entry_index;
      load_q[0].coef  <= {in_if.coef_square, in_if.coef_linear, in_if.coef_constant};
      for (int k = 1; k <= LAST; k++) side_q[k] <= side_q[k-1];
      for (int k = 1; k < IDX; k++) load_q[k] <= load_q[k-1];
    end
  end

  // x - origin, then times scale
  logic [gpq_pkg::FP_W-1:0] diff_y, pos_y;

  gpq_fp_add u_add_org (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (side_q[0].x),
    .b_i   ({~origin_q[31], origin_q[30:0]}),
    .y_o   (diff_y)
  );

  gpq_fp_mul u_mul_scale (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (diff_y),
    .b_i   (scale_q),
    .y_o   (pos_y)
  );

  // truncate to segment, saturate to the table
  logic [7:0]                   t_exp;
  logic                         t_nan;
  logic [23:0]                  t_shift;
  logic [gpq_pkg::SEG_INT_W-1:0] t_int;
  logic [IW-1:0]                idx_d, idx_q;
  logic                         wr_d, wr_q;
  logic [IW-1:0]                waddr_q;
  logic [gpq_pkg::COEF_W-1:0]   wdata_q;

  always_comb begin
    t_exp   = pos_y[30:23];
    t_nan   = (t_exp == 8'hFF) && (pos_y[22:0] != 23'd0);
    t_shift = {1'b1, pos_y[22:0]} >> (8'd150 - t_exp);
    t_int   = t_shift[gpq_pkg::SEG_INT_W-1:0];
    if (pos_y[31] || t_nan || t_exp < 8'd127) idx_d = '0;
    else if (t_exp >= 8'd144) idx_d = IW'(TABLE_DEPTH - 1);
    else if (t_int >= gpq_pkg::SEG_INT_W'(TABLE_DEPTH)) idx_d = IW'(TABLE_DEPTH - 1);
    else idx_d = t_int[IW-1:0];
    wr_d = (side_q[MUL1_OUT].kind == gpq_pkg::KIND_LOAD) &&
           ({{(gpq_pkg::SEG_INT_W - gpq_pkg::ENTRY_W){1'b0}}, load_q[MUL1_OUT].entry}
            < gpq_pkg::SEG_INT_W'(TABLE_DEPTH));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      idx_q   <= idx_d;
      wr_q    <= wr_d;
      waddr_q <= IW'(load_q[MUL1_OUT].entry);
      wdata_q <= load_q[MUL1_OUT].coef;
    end
  end

  logic [gpq_pkg::COEF_W-1:0] coef;

  gpq_coef_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .en_i    (adv),
    .we_i    (v_q[IDX] && wr_q),
    .waddr_i (waddr_q),
    .wdata_i (wdata_q),
    .raddr_i (idx_q),
    .rdata_o (coef)
  );

  // c1 is due two stages after the RAM, c0 six
  logic [gpq_pkg::FP_W-1:0] c1_q [ADD2_IN-COEF];
  logic [gpq_pkg::FP_W-1:0] c0_q [ADD3_IN-COEF];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q[0] <= coef[2*gpq_pkg::FP_W-1:gpq_pkg::FP_W];
      c0_q[0] <= coef[gpq_pkg::FP_W-1:0];
      for (int k = 1; k < ADD2_IN - COEF; k++) c1_q[k] <= c1_q[k-1];
      for (int k = 1; k < ADD3_IN - COEF; k++) c0_q[k] <= c0_q[k-1];
    end
  end

  logic [gpq_pkg::FP_W-1:0] p2_y, p1_y, px_y, p0_y;

  gpq_fp_mul u_mul_c2 (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (coef[3*gpq_pkg::FP_W-1:2*gpq_pkg::FP_W]),
    .b_i   (side_q[COEF].x),
    .y_o   (p2_y)
  );

  gpq_fp_add u_add_c1 (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (p2_y),
    .b_i   (c1_q[ADD2_IN-COEF-1]),
    .y_o   (p1_y)
  );

  gpq_fp_mul u_mul_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (p1_y),
    .b_i   (side_q[MUL3_IN].x),
    .y_o   (px_y)
  );

  gpq_fp_add u_add_c0 (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (px_y),
    .b_i   (c0_q[ADD3_IN-COEF-1]),
    .y_o   (p0_y)
  );

  logic [gpq_pkg::FP_W-1:0] y_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (side_q[ADD3_OUT].lo) y_q <= '0;
      else if (side_q[ADD3_OUT].hi) y_q <= side_q[ADD3_OUT].x;
      else y_q <= p0_y;
    end
  end

  assign out_if.valid  = v_q[LAST] && (side_q[LAST].kind == gpq_pkg::KIND_EVAL);
  assign out_if.y_bits = y_q;

`ifndef NO_ASSERTIONS
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v_q))
    else $error("pipeline moved while stalled");

  a_hi_passes_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && side_q[LAST].hi |-> out_if.y_bits == side_q[LAST].x)
    else $error("large input not passed through");

  a_lo_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && side_q[LAST].lo |-> out_if.y_bits == '0)
    else $error("small input not zero");

  a_nan_canon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.y_bits[30:23] == 8'hFF && out_if.y_bits[22:0] != 23'd0
    |-> out_if.y_bits == gpq_pkg::CANON_NAN)
    else $error("non-canonical NaN result");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the piecewise quadratic GELU stream block.
`timescale 1ns / 1ps

module testbench;
  import gpq_pkg::*;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 400;

  class gelu_scoreboard;
    logic [FP_W-1:0]   origin;
    logic [FP_W-1:0]   scale;
    logic [COEF_W-1:0] coef_tab [TABLE_DEPTH];
    bit                written [TABLE_DEPTH];
    logic [FP_W-1:0]   expected_y [$];
    int                errors;

    function new();
      origin = ORIGIN_RESET;
      scale  = SCALE_RESET;
      errors = 0;
    endfunction

    static function real to_real(logic [FP_W-1:0] b);
      logic [7:0] e;
      real v;
      e = b[30:23];
      if (e == 8'hFF) return $bitstoreal({b[31], 11'h7FF, b[22:0], 29'd0});
      if (e == 8'd0) begin
        v = real'(b[22:0]) * $bitstoreal({1'b0, 11'd874, 52'd0});
        return b[31] ? -v : v;
      end
      return $bitstoreal({b[31], 11'(int'(e) + 896), b[22:0], 29'd0});
    endfunction

    // round a double to binary32, nearest even, with subnormals
    static function logic [FP_W-1:0] to_bits(real r);
      logic [63:0] d;
      logic [63:0] m;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      logic s;
      int ex;
      int sh;
      int bexp;
      d = $realtobits(r);
      s = d[63];
      if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? CANON_NAN : {s, 8'hFF, 23'd0};
      if (d[62:52] == 11'd0) return {s, 31'd0};
      ex = int'(d[62:52]) - 1023;
      if (ex > 127) return {s, 8'hFF, 23'd0};
      m  = {11'd0, 1'b1, d[51:0]};
      sh = (ex >= -126) ? 29 : 29 + (-126 - ex);
      if (sh >= 64) return {s, 31'd0};
      q    = m >> sh;
      rem  = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      if (ex >= -126) begin
        bexp = ex + 127;
        if (q[24]) begin
          q = q >> 1;
          bexp++;
        end
        if (bexp >= 255) return {s, 8'hFF, 23'd0};
        return {s, 8'(bexp), q[22:0]};
      end
      return {s, q[30:0]};
    endfunction

    static function real rnd(real r);
      return to_real(to_bits(r));
    endfunction

    function int segment_for(logic [FP_W-1:0] xb);
      real t;
      t = rnd(rnd(to_real(xb) - to_real(origin)) * to_real(scale));
      if (!(t >= 0.0)) return 0;
      if (t >= real'(TABLE_DEPTH)) return TABLE_DEPTH - 1;
      return $rtoi(t);
    endfunction

    function bit on_poly_path(logic [FP_W-1:0] xb);
      real x;
      x = to_real(xb);
      return !(x < -5.0) && !(x > 5.0);
    endfunction

    function logic [FP_W-1:0] gelu_of(logic [FP_W-1:0] xb);
      real x;
      real p;
      logic [COEF_W-1:0] c;
      x = to_real(xb);
      if (x < -5.0) return '0;
      if (x > 5.0) return xb;
      c = coef_tab[segment_for(xb)];
      p = rnd(to_real(c[95:64]) * x);
      p = rnd(p + to_real(c[63:32]));
      p = rnd(p * x);
      p = rnd(p + to_real(c[31:0]));
      return to_bits(p);
    endfunction

    function void note_request(logic kind, logic [FP_W-1:0] xb, logic [ENTRY_W-1:0] idx,
                               logic [COEF_W-1:0] coefs);
      if (kind == KIND_LOAD) begin
        if (idx < TABLE_DEPTH) begin
          coef_tab[idx] = coefs;
          written[idx]  = 1'b1;
        end
      end else begin
        expected_y.push_back(gelu_of(xb));
      end
    endfunction

    function void check_result(logic [FP_W-1:0] y);
      logic [FP_W-1:0] e;
      if (expected_y.size() == 0) begin
        $error("unexpected result y_bits=%h", y);
        errors++;
        return;
      end
      e = expected_y.pop_front();
      if (y !== e) begin
        $error("y_bits mismatch: expected %h actual %h", e, y);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int max_gap;
  bit hold_off;
  int idle_cycles;
  gelu_scoreboard sb;

  gpq_in_if  in_ch ();
  gpq_out_if out_ch ();

  gelu_piecewise_quadratic uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check_result(out_ch.y_bits);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // result side
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off = 1'b0;
      end
      n = $urandom_range(0, max_gap);
      if (n > 0) begin
        out_ch.ready = 1'b0;
        repeat (n) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      @(negedge clk_i);
    end
  end

  task automatic send(logic kind, logic [FP_W-1:0] xb, logic [ENTRY_W-1:0] idx,
                      logic [COEF_W-1:0] coefs);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.kind          = kind;
    in_ch.x_bits        = xb;
    in_ch.entry_index   = idx;
    in_ch.coef_square   = coefs[95:64];
    in_ch.coef_linear   = coefs[63:32];
    in_ch.coef_constant = coefs[31:0];
    in_ch.valid         = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_request(kind, xb, idx, coefs);
    @(negedge clk_i);
  endtask

  function automatic logic [FP_W-1:0] rand_coef();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return gelu_scoreboard::to_bits((real'($urandom_range(0, 20000)) - 10000.0) / 5000.0);
  endfunction

  function automatic logic [COEF_W-1:0] rand_coefs();
    return {rand_coef(), rand_coef(), rand_coef()};
  endfunction

  task automatic send_load(int idx, logic [COEF_W-1:0] coefs);
    send(KIND_LOAD, $urandom, ENTRY_W'(idx), coefs);
  endtask

  // any table entry the evaluation will read gets loaded first
  task automatic send_eval(logic [FP_W-1:0] xb);
    int k;
    if (sb.on_poly_path(xb)) begin
      k = sb.segment_for(xb);
      if (!sb.written[k]) send_load(k, rand_coefs());
    end
    send(KIND_EVAL, xb, ENTRY_W'($urandom), {$urandom, $urandom, $urandom});
  endtask

  function automatic logic [FP_W-1:0] rand_x();
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: return {1'($urandom), 8'($urandom_range(124, 130)), 23'($urandom)};
      default: return gelu_scoreboard::to_bits((real'($urandom_range(0, 12000)) - 6000.0)
                                                 / 1000.0);
    endcase
  endfunction

  task automatic drain();
    in_ch.valid = 1'b0;
    while (sb.expected_y.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk_i);
    cfg_we = 1'b0;
    if (idx == REG_SEG_ORIGIN) sb.origin = data;
    else sb.scale = data;
  endtask

  initial begin
    logic [FP_W-1:0] directed_x [16];
    logic [FP_W-1:0] origins [8];
    logic [FP_W-1:0] scales [8];
    sb = new();
    max_gap     = 11;
    hold_off    = 1'b0;
    idle_cycles = 0;
    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = REG_SEG_ORIGIN;
    cfg_data    = '0;
    in_ch.valid = 1'b0;
    in_ch.kind  = KIND_EVAL;
    in_ch.x_bits = '0;
    in_ch.entry_index = '0;
    in_ch.coef_square = '0;
    in_ch.coef_linear = '0;
    in_ch.coef_constant = '0;
    directed_x = '{32'hC0A0_0000, 32'h40A0_0000, 32'hC0A0_0001, 32'h40A0_0001,
                   32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                   32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7F7F_FFFF,
                   32'hFF7F_FFFF, 32'h409F_FFFF, 32'hC09F_FFFF, 32'h3F80_0000};
    origins = '{ORIGIN_RESET, 32'hC0A0_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                32'h40A0_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h0000_0000};
    scales  = '{SCALE_RESET, 32'h42C8_0000, 32'h0000_0000, 32'h7F80_0000,
                32'hC2C8_0000, 32'h3F80_0000, 32'h3F80_0000, 32'hFFFF_FFFF};
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // NaN coefficients in entry 0, then infinite ones there, then the boundary and special inputs
    send_load(0, {96{1'b1}});
    send_eval(32'hC0A0_0000);
    send_load(0, {32'h7F80_0000, 32'hFF80_0000, 32'h0000_0000});
    send_load(TABLE_DEPTH - 1, rand_coefs());
    foreach (directed_x[i]) send_eval(directed_x[i]);
    drain();
    write_reg(REG_SEG_SCALE, 32'h4B00_0000);
    send_eval(32'h409F_FFFF);
    send_eval(32'h0000_0000);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_reg(REG_SEG_ORIGIN, origins[ph]);
      write_reg(REG_SEG_SCALE, scales[ph]);
      max_gap = (ph % 3 == 2) ? 0 : 11;
      if (ph == 1) hold_off = 1'b1;
      for (int n = 0; n < 115; n++) begin
        if ($urandom_range(0, 6) == 0) send_load($urandom_range(0, TABLE_DEPTH - 1),
                                                  rand_coefs());
        else send_eval(rand_x());
      end
    end
    drain();
    sb.errors += sb.expected_y.size();
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
